[src/rbf_pkg.sv]
package rbf_pkg;

  localparam int DEPTH    = 256;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int DATA_W   = 8;
  localparam int CFG_W    = 4;
  localparam int READ_MAX = 64;
  localparam int CNT_W    = $clog2(READ_MAX + 1);

  localparam logic [CFG_W-1:0] DATA_BITS_RST = CFG_W'(8);
  localparam logic [CFG_W-1:0] DATA_BITS_6   = CFG_W'(6);
  localparam logic [CFG_W-1:0] DATA_BITS_8   = CFG_W'(8);

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  typedef struct packed {
    logic  we;
    logic  re;
    ptr_t  addr;
    byte_t wdata;
  } ram_req_t;

  typedef struct packed {
    logic valid;
    logic has_data;
    logic is_last;
  } out_stat_t;

  typedef struct packed {
    ptr_t rd_ptr;
    ptr_t wr_ptr;
  } ptr_stat_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t n;
    n = (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  function automatic byte_t width_mask(input cfg_t bits);
    byte_t m;
    if (bits < DATA_BITS_8) begin
      m = (bits == DATA_BITS_6) ? 8'h3f : 8'h7f;
    end else begin
      m = 8'hff;
    end
    return m;
  endfunction

endpackage

[src/rbf_if.sv]
interface rbf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [rbf_pkg::DATA_W-1:0]          rx_byte;
  logic [rbf_pkg::CNT_W-1:0]           read_count;

  modport source (output valid, op, rx_byte, read_count, input ready);
  modport sink   (input valid, op, rx_byte, read_count, output ready);
endinterface

interface rbf_out_if;
  logic                                valid;
  logic                                ready;
  logic [rbf_pkg::DATA_W-1:0]          out_byte;
  logic                                has_data;
  logic                                is_last;

  modport source (output valid, out_byte, has_data, is_last, input ready);
  modport sink   (input valid, out_byte, has_data, is_last, output ready);
endinterface

[src/rbf_ram.sv]
module rbf_ram (
  input  logic              clk,
  input  rbf_pkg::ram_req_t req,
  output rbf_pkg::byte_t    rdata
);
  import rbf_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rbf_ctrl.sv]
module rbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  rbf_pkg::byte_t     in_rx_byte,
  input  rbf_pkg::cnt_t      in_read_count,
  input  logic               out_ready,
  output rbf_pkg::out_stat_t out_stat,
  output rbf_pkg::ram_req_t  ram_req,
  output rbf_pkg::ptr_stat_t ptr_stat
);
  import rbf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  ptr_t   rd_ptr_r, rd_ptr_nxt;
  ptr_t   wr_ptr_r, wr_ptr_nxt;
  cnt_t   left_r, left_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   has_data_r, has_data_nxt;
  logic   is_last_r, is_last_nxt;
  logic   accept;
  logic   slot_free;
  ptr_t   rd_step;
  ptr_t   wr_step;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign rd_step   = ptr_next(rd_ptr_r);
  assign wr_step   = ptr_next(wr_ptr_r);

  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    left_nxt      = left_r;
    has_data_nxt  = has_data_r;
    is_last_nxt   = is_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_req       = '0;
    ram_req.addr  = rd_ptr_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_READ) begin
            if (in_read_count != '0) begin
              left_nxt  = (in_read_count > cnt_t'(READ_MAX)) ? cnt_t'(READ_MAX)
                                                            : in_read_count;
              state_nxt = ST_READ;
            end
          end else begin
            ram_req.we    = 1'b1;
            ram_req.addr  = wr_ptr_r;
            ram_req.wdata = in_rx_byte;
            wr_ptr_nxt    = wr_step;
            if (rd_ptr_r == wr_step) begin
              rd_ptr_nxt = rd_step;
            end
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (rd_ptr_r == wr_ptr_r) begin
            has_data_nxt = 1'b0;
            is_last_nxt  = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            ram_req.re   = 1'b1;
            rd_ptr_nxt   = rd_step;
            left_nxt     = left_r - 1'b1;
            has_data_nxt = 1'b1;
            is_last_nxt  = (left_r == cnt_t'(1)) || (rd_step == wr_ptr_r);
            if (is_last_nxt) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    left_r     <= left_nxt;
    has_data_r <= has_data_nxt;
    is_last_r  <= is_last_nxt;
  end

  assign out_stat.valid    = out_valid_r;
  assign out_stat.has_data = has_data_r;
  assign out_stat.is_last  = is_last_r;
  assign ptr_stat.rd_ptr   = rd_ptr_r;
  assign ptr_stat.wr_ptr   = wr_ptr_r;

endmodule

[src/rx_byte_fifo_drop_oldest.sv]
// Receive item: gives no result; the next item can be accepted the cycle after.
// Read item: after acceptance the controller enters its read state and issues
// memory reads, one result per cycle while out_ch.ready is high (one memory read port).
// Next item accepted once a request's last result is produced and the state is idle again.
// Reset (rst_n low, synchronous): pointers cleared, data_bits set to 8;
// memory contents are not cleared and need no clearing pass.
module rx_byte_fifo_drop_oldest (
  input  logic                 clk,
  input  logic                 rst_n,
  rbf_in_if.sink               in_ch,
  rbf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [rbf_pkg::CFG_W-1:0] cfg_wdata
);
  import rbf_pkg::*;

  cfg_t      data_bits_r;
  ram_req_t  ram_req;
  byte_t     ram_rdata;
  out_stat_t out_stat;
  ptr_stat_t ptr_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= DATA_BITS_RST;
    end else if (cfg_we) begin
      data_bits_r <= cfg_wdata;
    end
  end

  rbf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_op         (in_ch.op),
    .in_rx_byte    (in_ch.rx_byte),
    .in_read_count (in_ch.read_count),
    .out_ready     (out_ch.ready),
    .out_stat      (out_stat),
    .ram_req       (ram_req),
    .ptr_stat      (ptr_stat)
  );

  rbf_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  assign out_ch.valid    = out_stat.valid;
  assign out_ch.has_data = out_stat.has_data;
  assign out_ch.is_last  = out_stat.is_last;
  assign out_ch.out_byte = out_stat.has_data ? (ram_rdata & width_mask(data_bits_r)) : '0;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.re))
    else $error("memory read and write in the same cycle");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_data) |-> (out_ch.is_last && out_ch.out_byte == '0))
    else $error("no-data result not final or not zero");

  a_recv_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_RECV)
      |=> (ptr_stat.rd_ptr != ptr_stat.wr_ptr))
    else $error("ring empty after a receive item");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.re |-> !in_ch.ready)
    else $error("input ready during a read burst");

endmodule
